### sv/vlp_pkg.sv
`timescale 1ns / 1ps

package vlp_pkg;

   localparam int CHANNELS        = 6;
   localparam int CH_W            = $clog2(CHANNELS);
   localparam int ALPHA_FRAC_BITS = 24;
   localparam int ALPHA_CNT_W     = $clog2(ALPHA_FRAC_BITS);
   localparam int PROD_W          = ALPHA_FRAC_BITS + 32;
   localparam int WIDE_W          = 96;

   // round(2*pi * 2^28)
   localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
   // 10^6 * 2^44: turns cutoff(Q16.16) * dt(us) * 2pi(Q28) into radians
   localparam logic [63:0] DT_SCALE   = 64'd17592186044416000000;
   localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (ALPHA_FRAC_BITS - 1);

   typedef struct packed {
      logic        [31:0] stamp_us;
      logic signed [31:0] lin_x;
      logic signed [31:0] lin_y;
      logic signed [31:0] lin_z;
      logic signed [31:0] ang_x;
      logic signed [31:0] ang_y;
      logic signed [31:0] ang_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] lin_x_out;
      logic signed [31:0] lin_y_out;
      logic signed [31:0] lin_z_out;
      logic signed [31:0] ang_x_out;
      logic signed [31:0] ang_y_out;
      logic signed [31:0] ang_z_out;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL_P,
      OP_MUL_NLO,
      OP_MUL_NHI,
      OP_ADD_N,
      OP_ADD_S,
      OP_NORM,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_CH_MUL,
      OP_CH_UPD,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_START,
      COND_S_BIG,
      COND_CNT_NZ,
      COND_CH_MORE,
      COND_RSP_BUSY
   } cond_type;

   typedef enum logic [3:0] {
      STEP_IDLE,
      STEP_MUL_P,
      STEP_MUL_NLO,
      STEP_MUL_NHI,
      STEP_ADD_N,
      STEP_ADD_S,
      STEP_NORM,
      STEP_DIV_INIT,
      STEP_DIV,
      STEP_CH_MUL,
      STEP_CH_UPD,
      STEP_WAIT,
      STEP_EMIT
   } step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   typedef struct packed {
      logic start;
      logic s_big;
      logic cnt_nz;
      logic ch_more;
      logic rsp_busy;
   } seq_status_type;

   function automatic ucode_type ucode_rom(input step_type pc);
      ucode_type w;
      unique case (pc)
         STEP_IDLE:     w = '{OP_LOAD,     COND_NO_START, STEP_IDLE};
         STEP_MUL_P:    w = '{OP_MUL_P,    COND_NONE,     STEP_IDLE};
         STEP_MUL_NLO:  w = '{OP_MUL_NLO,  COND_NONE,     STEP_IDLE};
         STEP_MUL_NHI:  w = '{OP_MUL_NHI,  COND_NONE,     STEP_IDLE};
         STEP_ADD_N:    w = '{OP_ADD_N,    COND_NONE,     STEP_IDLE};
         STEP_ADD_S:    w = '{OP_ADD_S,    COND_NONE,     STEP_IDLE};
         STEP_NORM:     w = '{OP_NORM,     COND_S_BIG,    STEP_NORM};
         STEP_DIV_INIT: w = '{OP_DIV_INIT, COND_NONE,     STEP_IDLE};
         STEP_DIV:      w = '{OP_DIV_STEP, COND_CNT_NZ,   STEP_DIV};
         STEP_CH_MUL:   w = '{OP_CH_MUL,   COND_NONE,     STEP_IDLE};
         STEP_CH_UPD:   w = '{OP_CH_UPD,   COND_CH_MORE,  STEP_CH_MUL};
         STEP_WAIT:     w = '{OP_NOP,      COND_RSP_BUSY, STEP_WAIT};
         STEP_EMIT:     w = '{OP_EMIT,     COND_ALWAYS,   STEP_IDLE};
         default:       w = '{OP_NOP,      COND_ALWAYS,   STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

### sv/vlp_ifs.sv
`timescale 1ns / 1ps

interface vlp_req_if;
   logic                      valid;
   logic                      ready;
   vlp_pkg::req_payload_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface vlp_rsp_if;
   logic                      valid;
   logic                      ready;
   vlp_pkg::rsp_payload_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### sv/six_axis_variable_step_lowpass_core.sv
`timescale 1ns / 1ps

// Variable-step first-order low-pass over six velocity components.
// req_bus carries one beat per sample: a 32-bit microsecond stamp and six
// signed Q16.16 values. rsp_bus returns one beat per sample with the six
// filtered values. csr_wr_en/csr_wr_data write the cutoff (Q16.16 Hz);
// write it only while the block is idle.
// A small microcode program steps a shared datapath: one 32x32 multiply
// for cutoff*dt, two 32x31 partial products for the 2*pi scaling, a
// one-bit-per-cycle normalize loop, a 24-step restoring divide for alpha,
// and one 24x32 multiply-add per channel, as a multiply step and an update step.
// The normalize loop makes 1 to 32 shifts, set by the size of cutoff*dt;
// the next req beat can be taken in the same cycle that rsp goes valid.
// The rsp beat sits in its own register, so the next sample is accepted
// and worked on while the receiver stalls; the program only waits before
// publishing if the previous beat is still held.
// Reset clears the filter state and the stored stamp to zero and loads a
// cutoff of 1 Hz; the first sample measures dt from stamp zero.
module six_axis_variable_step_lowpass_core (
   input  logic                    clock,
   input  logic                    reset,
   vlp_req_if.sink                 req_bus,
   vlp_rsp_if.source               rsp_bus,
   input  logic                    csr_wr_en,
   input  logic [31:0]             csr_wr_data
);

   localparam int CH = vlp_pkg::CHANNELS;
   localparam int AF = vlp_pkg::ALPHA_FRAC_BITS;
   localparam int WW = vlp_pkg::WIDE_W;

   vlp_pkg::ucode_type      ctl;
   vlp_pkg::seq_status_type status;

   // configuration and stored state
   logic [31:0]               cutoff_ff, cutoff_in;
   logic [31:0]               last_ff, last_in;
   logic [31:0]               filt_ff [CH];
   logic [31:0]               filt_in [CH];
   logic [31:0]               x_ff [CH];
   logic [31:0]               x_in [CH];

   // alpha datapath
   logic [31:0]               dt_ff, dt_in;
   logic [63:0]               p_ff, p_in;
   logic [WW-1:0]             n_ff, n_in;
   logic [WW-1:0]             s_ff, s_in;
   logic [62:0]               r_ff, r_in;
   logic [AF-1:0]             alpha_ff, alpha_in;
   logic [vlp_pkg::ALPHA_CNT_W-1:0] cnt_ff, cnt_in;

   // channel datapath
   logic [vlp_pkg::CH_W-1:0]  ch_ff, ch_in;
   logic                      neg_ff, neg_in;
   logic [vlp_pkg::PROD_W-1:0] prod_ff, prod_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   vlp_pkg::rsp_payload_type  rsp_data_ff, rsp_data_in;

   logic                      start;
   logic                      s_big;
   logic [63:0]               r_dbl;
   logic [32:0]               diff;
   logic [32:0]               mag;
   logic [vlp_pkg::PROD_W:0]  rounded;
   logic [31:0]               step_mag;

   assign req_bus.ready   = (ctl.op == vlp_pkg::OP_LOAD);
   assign start           = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

   assign s_big = |s_ff[WW-1:63];

   assign status.start    = start;
   assign status.s_big    = s_big;
   assign status.cnt_nz   = (cnt_ff != '0);
   assign status.ch_more  = (ch_ff != vlp_pkg::CH_W'(CH - 1));
   assign status.rsp_busy = rsp_valid_ff && !rsp_bus.ready;

   vlp_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   // shared arithmetic
   assign r_dbl    = {r_ff, 1'b0};
   assign diff     = {x_ff[ch_ff][31], x_ff[ch_ff]} - {filt_ff[ch_ff][31], filt_ff[ch_ff]};
   assign mag      = diff[32] ? (~diff + 33'd1) : diff;
   assign rounded  = {1'b0, prod_ff} + vlp_pkg::ROUND_HALF;
   assign step_mag = rounded[AF+31:AF];

   always_comb begin
      cutoff_in    = cutoff_ff;
      last_in      = last_ff;
      filt_in      = filt_ff;
      x_in         = x_ff;
      dt_in        = dt_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      s_in         = s_ff;
      r_in         = r_ff;
      alpha_in     = alpha_ff;
      cnt_in       = cnt_ff;
      ch_in        = ch_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // drop the held beat once the receiver takes it
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         cutoff_in = csr_wr_data;
      end

      unique case (ctl.op)
         vlp_pkg::OP_LOAD: begin
            if (start) begin
               x_in[0] = req_bus.payload.lin_x;
               x_in[1] = req_bus.payload.lin_y;
               x_in[2] = req_bus.payload.lin_z;
               x_in[3] = req_bus.payload.ang_x;
               x_in[4] = req_bus.payload.ang_y;
               x_in[5] = req_bus.payload.ang_z;
               // elapsed time wraps modulo 2^32
               dt_in   = req_bus.payload.stamp_us - last_ff;
               last_in = req_bus.payload.stamp_us;
            end
         end
         vlp_pkg::OP_MUL_P: begin
            p_in = cutoff_ff * dt_ff;
         end
         vlp_pkg::OP_MUL_NLO: begin
            n_in = WW'({32'd0, p_ff[31:0]} * {33'd0, vlp_pkg::TWO_PI_Q28});
         end
         vlp_pkg::OP_MUL_NHI: begin
            // hold the upper partial product in p until the add
            p_in = {32'd0, p_ff[63:32]} * {33'd0, vlp_pkg::TWO_PI_Q28};
         end
         vlp_pkg::OP_ADD_N: begin
            n_in = n_ff + {p_ff[WW-33:0], 32'd0};
         end
         vlp_pkg::OP_ADD_S: begin
            s_in = n_ff + WW'(vlp_pkg::DT_SCALE);
         end
         vlp_pkg::OP_NORM: begin
            // shift numerator and denominator together until S < 2^63
            if (s_big) begin
               n_in = n_ff >> 1;
               s_in = s_ff >> 1;
            end
         end
         vlp_pkg::OP_DIV_INIT: begin
            r_in     = n_ff[62:0];
            alpha_in = '0;
            cnt_in   = vlp_pkg::ALPHA_CNT_W'(AF - 1);
            ch_in    = '0;
         end
         vlp_pkg::OP_DIV_STEP: begin
            if (r_dbl >= {1'b0, s_ff[62:0]}) begin
               r_in     = 63'(r_dbl - {1'b0, s_ff[62:0]});
               alpha_in = {alpha_ff[AF-2:0], 1'b1};
            end else begin
               r_in     = r_dbl[62:0];
               alpha_in = {alpha_ff[AF-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
         end
         vlp_pkg::OP_CH_MUL: begin
            neg_in  = diff[32];
            prod_in = alpha_ff * mag[31:0];
         end
         vlp_pkg::OP_CH_UPD: begin
            filt_in[ch_ff] = neg_ff ? (filt_ff[ch_ff] - step_mag)
                                    : (filt_ff[ch_ff] + step_mag);
            ch_in          = ch_ff + 1'b1;
         end
         vlp_pkg::OP_EMIT: begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.lin_x_out = filt_ff[0];
            rsp_data_in.lin_y_out = filt_ff[1];
            rsp_data_in.lin_z_out = filt_ff[2];
            rsp_data_in.ang_x_out = filt_ff[3];
            rsp_data_in.ang_y_out = filt_ff[4];
            rsp_data_in.ang_z_out = filt_ff[5];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff    <= 32'd65536;
         last_ff      <= '0;
         filt_ff      <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         cutoff_ff    <= cutoff_in;
         last_ff      <= last_in;
         filt_ff      <= filt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      dt_ff       <= dt_in;
      p_ff        <= p_in;
      n_ff        <= n_in;
      s_ff        <= s_in;
      r_ff        <= r_in;
      alpha_ff    <= alpha_in;
      cnt_ff      <= cnt_in;
      ch_ff       <= ch_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   // an accepted beat always starts the alpha program
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      start |=> (ctl.op == vlp_pkg::OP_MUL_P))
      else $error("accepted beat did not start the program");

   // normalize leaves S in [2^62, 2^63) and N below S
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == vlp_pkg::OP_DIV_INIT) |-> (!s_big && s_ff[62] && (n_ff < s_ff)))
      else $error("divider operands out of range");

   // never overwrite a result the receiver has not taken
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == vlp_pkg::OP_EMIT) |-> !rsp_valid_ff)
      else $error("result register overwritten");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == vlp_pkg::OP_EMIT) |=> rsp_valid_ff)
      else $error("publish did not raise valid");

endmodule

### sv/vlp_useq.sv
`timescale 1ns / 1ps

module vlp_useq (
   input  logic                     clock,
   input  logic                     reset,
   input  vlp_pkg::seq_status_type  status,
   output vlp_pkg::ucode_type       ctl
);

   vlp_pkg::step_type pc_ff;
   vlp_pkg::step_type pc_in;
   logic              take_jump;

   assign ctl = vlp_pkg::ucode_rom(pc_ff);

   always_comb begin
      unique case (ctl.cond)
         vlp_pkg::COND_NONE:     take_jump = 1'b0;
         vlp_pkg::COND_ALWAYS:   take_jump = 1'b1;
         vlp_pkg::COND_NO_START: take_jump = !status.start;
         vlp_pkg::COND_S_BIG:    take_jump = status.s_big;
         vlp_pkg::COND_CNT_NZ:   take_jump = status.cnt_nz;
         vlp_pkg::COND_CH_MORE:  take_jump = status.ch_more;
         vlp_pkg::COND_RSP_BUSY: take_jump = status.rsp_busy;
         default:                take_jump = 1'b1;
      endcase
      pc_in = take_jump ? ctl.target : vlp_pkg::step_type'(pc_ff + 4'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= vlp_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
